FILE: hw/rtl/bss_pkg.sv
// Shared types and constants for the JPEG scan byte stuffer.
// Used by bss_front, bss_queue, bss_back and jpeg_scan_byte_stuffer.
package bss_pkg;

    localparam int CAP_W = 21;
    localparam logic [CAP_W-1:0] CAP_RESET = 21'd524288;

    localparam logic [7:0] BYTE_FF = 8'hff;
    localparam logic [7:0] BYTE_SOI = 8'hd8;
    localparam logic [7:0] BYTE_EOI = 8'hd9;
    localparam logic [7:0] BYTE_RST0 = 8'hd0;
    localparam logic [7:0] BYTE_RST7 = 8'hd7;
    localparam logic [7:0] BYTE_TEM = 8'h01;
    localparam logic [7:0] BYTE_DRI = 8'hdd;
    localparam logic [7:0] BYTE_SOS = 8'hda;
    localparam logic [7:0] BYTE_ZERO = 8'h00;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_BAD_START = 3'd1;
    localparam logic [2:0] ST_BAD_HEADER = 3'd2;
    localparam logic [2:0] ST_RESTART = 3'd3;
    localparam logic [2:0] ST_NO_SCAN = 3'd4;
    localparam logic [2:0] ST_NO_END = 3'd5;
    localparam logic [2:0] ST_CAPACITY = 3'd6;

    typedef enum logic [3:0] {
        PH_START = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_SCAN = 4'b0100,
        PH_DRAIN = 4'b1000
    } phase_t;

    typedef enum logic [4:0] {
        HS_PREFIX = 5'b00001,
        HS_MARK = 5'b00010,
        HS_LEN_HI = 5'b00100,
        HS_LEN_LO = 5'b01000,
        HS_BODY = 5'b10000
    } hstep_t;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       last;
        logic [2:0] status;
    } res_t;

    typedef struct packed {
        logic [2:0]       count;
        res_t [3:0]       res;
    } cmd_t;

    function automatic logic is_standalone(input logic [7:0] b);
        return (b == BYTE_SOI) || ((b >= BYTE_RST0) && (b <= BYTE_RST7)) || (b == BYTE_TEM);
    endfunction

    function automatic res_t mk_data(input logic [7:0] b, input logic last);
        res_t r;
        r.data = b;
        r.has = 1'b1;
        r.last = last;
        r.status = ST_OK;
        return r;
    endfunction

    function automatic res_t mk_status(input logic [2:0] st);
        res_t r;
        r.data = BYTE_ZERO;
        r.has = 1'b0;
        r.last = 1'b1;
        r.status = st;
        return r;
    endfunction

endpackage

FILE: hw/rtl/jpeg_scan_byte_stuffer.sv
// JPEG scan byte stuffer top level over bss_pkg: bss_front, bss_queue and bss_back.
// Path: each command is registered in the queue and then loaded into the output register that
// drives m_valid; scan bytes are held back by two input bytes to spot the closing FF D9.
// Throughput: one input byte per cycle while the queue has room; the output register moves one
// result per cycle while m_ready is high, with QUEUE_DEPTH commands buffered.
// Reset: aresetn is synchronous, active low; clears frame state and sets cap_reg to 524288.
module jpeg_scan_byte_stuffer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [bss_pkg::CAP_W-1:0] cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_in_byte,
    input  logic                      s_in_last,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [7:0]                m_out_byte,
    output logic                      m_has_byte,
    output logic                      m_out_last,
    output logic [2:0]                m_out_status
);
    import bss_pkg::*;

    cmd_t front_cmd, q_cmd;
    logic front_valid, q_ready, q_valid, q_pop;

    assign s_ready = q_ready;

    bss_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_in_byte   (s_in_byte),
        .s_in_last   (s_in_last),
        .q_ready     (q_ready),
        .cmd_valid   (front_valid),
        .cmd         (front_cmd)
    );

    bss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_cmd    (front_cmd),
        .in_ready  (q_ready),
        .out_valid (q_valid),
        .out_cmd   (q_cmd),
        .out_pop   (q_pop)
    );

    bss_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_has_byte   (m_has_byte),
        .m_out_last   (m_out_last),
        .m_out_status (m_out_status)
    );

endmodule

FILE: hw/rtl/bss_front.sv
// Front end: accepts frame bytes, walks the marker segments and builds result commands.
// Depends on bss_pkg; feeds bss_queue.
module bss_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [bss_pkg::CAP_W-1:0]     cfg_wr_data,
    input  logic                          s_valid,
    input  logic [7:0]                    s_in_byte,
    input  logic                          s_in_last,
    input  logic                          q_ready,
    output logic                          cmd_valid,
    output bss_pkg::cmd_t                 cmd
);
    import bss_pkg::*;

    logic [CAP_W-1:0] cap_reg;
    phase_t           phase_reg, phase_next;
    hstep_t           hstep_reg, hstep_next;
    logic [15:0]      seg_left_reg, seg_left_next;
    logic [7:0]       len_hi_reg, len_hi_next;
    logic [7:0]       marker_reg, marker_next;
    logic             restart_reg, restart_next;
    logic [7:0]       held0_reg, held0_next;
    logic [7:0]       held1_reg, held1_next;
    logic [1:0]       held_cnt_reg, held_cnt_next;
    logic [CAP_W-1:0] out_cnt_reg, out_cnt_next;
    logic [2:0]       err_reg, err_next;
    logic [2:0]       start_cnt_reg, start_cnt_next;

    logic             accept;
    logic [2:0]       sc_new;
    logic [15:0]      seg_full;
    logic [15:0]      seg_dec;
    logic [CAP_W:0]   out22, cnt1, cnt2, cap22, cnt;
    logic [2:0]       hend;
    logic             hend_bound;
    logic [2:0]       hb_err;
    logic             hb_sos;
    hstep_t           hb_hstep;
    logic [7:0]       hb_marker;
    logic [7:0]       hb_len_hi;
    logic [15:0]      hb_seg_left;
    logic             hb_restart;
    logic [2:0]       st;
    logic [7:0]       prev;

    assign accept = s_valid && q_ready;
    assign cmd_valid = accept && (cmd.count != 3'd0);

    always_comb begin
        sc_new = (start_cnt_reg < 3'd4) ? start_cnt_reg + 3'd1 : start_cnt_reg;
        seg_full = {len_hi_reg, s_in_byte};
        seg_dec = seg_left_reg - 16'd1;
        out22 = {1'b0, out_cnt_reg};
        cnt1 = out22 + 22'd1;
        cnt2 = out22 + 22'd2;
        cap22 = {1'b0, cap_reg};

        hend = ST_OK;
        hend_bound = 1'b0;
        unique case (hstep_reg)
            HS_PREFIX: hend = ST_NO_SCAN;
            HS_MARK: hend = is_standalone(s_in_byte) ? ST_NO_SCAN : ST_BAD_HEADER;
            HS_LEN_HI: hend = ST_BAD_HEADER;
            HS_LEN_LO: begin
                if (seg_full != 16'd2) hend = ST_BAD_HEADER;
                else hend_bound = 1'b1;
            end
            HS_BODY: begin
                if (seg_left_reg != 16'd1) hend = ST_BAD_HEADER;
                else hend_bound = 1'b1;
            end
            default: hend = ST_BAD_HEADER;
        endcase
        if (hend_bound) begin
            if (marker_reg != BYTE_SOS) hend = ST_NO_SCAN;
            else if (restart_reg || (marker_reg == BYTE_DRI)) hend = ST_RESTART;
            else hend = ST_NO_END;
        end

        hb_err = ST_OK;
        hb_sos = 1'b0;
        hb_hstep = hstep_reg;
        hb_marker = marker_reg;
        hb_len_hi = len_hi_reg;
        hb_seg_left = seg_left_reg;
        hb_restart = restart_reg;
        unique case (hstep_reg)
            HS_PREFIX: begin
                if (s_in_byte != BYTE_FF) hb_err = ST_BAD_HEADER;
                else hb_hstep = HS_MARK;
            end
            HS_MARK: begin
                if (s_in_byte == BYTE_FF) begin
                    hb_hstep = HS_MARK;
                end else if (is_standalone(s_in_byte)) begin
                    hb_hstep = HS_PREFIX;
                end else if (s_in_byte == BYTE_EOI) begin
                    hb_err = ST_BAD_HEADER;
                end else begin
                    hb_marker = s_in_byte;
                    hb_hstep = HS_LEN_HI;
                end
            end
            HS_LEN_HI: begin
                hb_len_hi = s_in_byte;
                hb_hstep = HS_LEN_LO;
            end
            HS_LEN_LO: begin
                if (seg_full < 16'd2) begin
                    hb_err = ST_BAD_HEADER;
                end else begin
                    if (marker_reg == BYTE_DRI) hb_restart = 1'b1;
                    if (seg_full == 16'd2) begin
                        hb_hstep = HS_PREFIX;
                        hb_sos = (marker_reg == BYTE_SOS);
                    end else begin
                        hb_seg_left = seg_full - 16'd2;
                        hb_hstep = HS_BODY;
                    end
                end
            end
            HS_BODY: begin
                hb_seg_left = seg_dec;
                if (seg_dec == 16'd0) begin
                    hb_hstep = HS_PREFIX;
                    hb_sos = (marker_reg == BYTE_SOS);
                end
            end
            default: hb_err = ST_BAD_HEADER;
        endcase

        phase_next = phase_reg;
        hstep_next = hstep_reg;
        seg_left_next = seg_left_reg;
        len_hi_next = len_hi_reg;
        marker_next = marker_reg;
        restart_next = restart_reg;
        held0_next = held0_reg;
        held1_next = held1_reg;
        held_cnt_next = held_cnt_reg;
        out_cnt_next = out_cnt_reg;
        err_next = err_reg;
        start_cnt_next = start_cnt_reg;
        cmd = '0;
        st = ST_OK;
        prev = held0_reg;
        cnt = out22;

        if (accept) begin
            start_cnt_next = sc_new;
            if (s_in_last) begin
                st = err_reg;
                if ((st == ST_OK) && (sc_new < 3'd4)) st = ST_BAD_START;
                if ((st == ST_OK) && (phase_reg == PH_HEADER)) st = hend;
                if ((st == ST_OK) && (phase_reg == PH_SCAN)) begin
                    prev = (held_cnt_reg == 2'd2) ? held1_reg : held0_reg;
                    if ((held_cnt_reg == 2'd0) || (prev != BYTE_FF) || (s_in_byte != BYTE_EOI)) begin
                        st = ST_NO_END;
                    end else begin
                        if (held_cnt_reg == 2'd2) begin
                            if (cnt2 > cap22) st = ST_CAPACITY;
                            else cnt = (held0_reg == BYTE_FF) ? cnt2 : cnt1;
                        end
                        if ((st == ST_OK) && (cnt <= cap22) && ((cnt + 22'd2) > cap22))
                            st = ST_CAPACITY;
                        if (st == ST_OK) begin
                            if (held_cnt_reg == 2'd2 && held0_reg == BYTE_FF) begin
                                cmd.count = 3'd4;
                                cmd.res[0] = mk_data(held0_reg, 1'b0);
                                cmd.res[1] = mk_data(BYTE_ZERO, 1'b0);
                                cmd.res[2] = mk_data(BYTE_FF, 1'b0);
                                cmd.res[3] = mk_data(BYTE_EOI, 1'b1);
                            end else if (held_cnt_reg == 2'd2) begin
                                cmd.count = 3'd3;
                                cmd.res[0] = mk_data(held0_reg, 1'b0);
                                cmd.res[1] = mk_data(BYTE_FF, 1'b0);
                                cmd.res[2] = mk_data(BYTE_EOI, 1'b1);
                            end else begin
                                cmd.count = 3'd2;
                                cmd.res[0] = mk_data(BYTE_FF, 1'b0);
                                cmd.res[1] = mk_data(BYTE_EOI, 1'b1);
                            end
                        end
                    end
                end
                if ((st != ST_OK) || (phase_reg == PH_START) || (phase_reg == PH_DRAIN)) begin
                    if (st == ST_OK) st = ST_BAD_START;
                    cmd = '0;
                    cmd.count = 3'd1;
                    cmd.res[0] = mk_status(st);
                end
                phase_next = PH_START;
                hstep_next = HS_PREFIX;
                seg_left_next = '0;
                len_hi_next = '0;
                marker_next = '0;
                restart_next = 1'b0;
                held0_next = '0;
                held1_next = '0;
                held_cnt_next = '0;
                out_cnt_next = '0;
                err_next = ST_OK;
                start_cnt_next = '0;
            end else begin
                unique case (phase_reg)
                    PH_START: begin
                        if (((sc_new == 3'd1) && (s_in_byte != BYTE_FF))
                                || ((sc_new == 3'd2) && (s_in_byte != BYTE_SOI))) begin
                            if (err_reg == ST_OK) err_next = ST_BAD_START;
                            phase_next = PH_DRAIN;
                        end else if (cnt1 > cap22) begin
                            if (err_reg == ST_OK) err_next = ST_CAPACITY;
                            phase_next = PH_DRAIN;
                        end else begin
                            out_cnt_next = cnt1[CAP_W-1:0];
                            cmd.count = 3'd1;
                            cmd.res[0] = mk_data(s_in_byte, 1'b0);
                            if (sc_new >= 3'd2) phase_next = PH_HEADER;
                        end
                    end
                    PH_HEADER: begin
                        hstep_next = hb_hstep;
                        seg_left_next = hb_seg_left;
                        len_hi_next = hb_len_hi;
                        marker_next = hb_marker;
                        restart_next = hb_restart;
                        if (hb_err != ST_OK) begin
                            if (err_reg == ST_OK) err_next = hb_err;
                            phase_next = PH_DRAIN;
                        end else if (hb_sos && hb_restart) begin
                            if (err_reg == ST_OK) err_next = ST_RESTART;
                            phase_next = PH_DRAIN;
                        end else if (cnt1 > cap22) begin
                            if (err_reg == ST_OK) err_next = ST_CAPACITY;
                            phase_next = PH_DRAIN;
                        end else begin
                            out_cnt_next = cnt1[CAP_W-1:0];
                            cmd.count = 3'd1;
                            cmd.res[0] = mk_data(s_in_byte, 1'b0);
                            if (hb_sos) begin
                                phase_next = PH_SCAN;
                                held_cnt_next = 2'd0;
                            end
                        end
                    end
                    PH_SCAN: begin
                        if (held_cnt_reg < 2'd2) begin
                            if (held_cnt_reg == 2'd0) held0_next = s_in_byte;
                            else held1_next = s_in_byte;
                            held_cnt_next = held_cnt_reg + 2'd1;
                        end else if (cnt2 > cap22) begin
                            if (err_reg == ST_OK) err_next = ST_CAPACITY;
                            phase_next = PH_DRAIN;
                        end else begin
                            cmd.res[0] = mk_data(held0_reg, 1'b0);
                            if (held0_reg == BYTE_FF) begin
                                cmd.count = 3'd2;
                                cmd.res[1] = mk_data(BYTE_ZERO, 1'b0);
                                out_cnt_next = cnt2[CAP_W-1:0];
                            end else begin
                                cmd.count = 3'd1;
                                out_cnt_next = cnt1[CAP_W-1:0];
                            end
                            held0_next = held1_reg;
                            held1_next = s_in_byte;
                        end
                    end
                    PH_DRAIN: phase_next = PH_DRAIN;
                    default: phase_next = PH_DRAIN;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
            phase_reg <= PH_START;
            hstep_reg <= HS_PREFIX;
            seg_left_reg <= '0;
            len_hi_reg <= '0;
            marker_reg <= '0;
            restart_reg <= 1'b0;
            held0_reg <= '0;
            held1_reg <= '0;
            held_cnt_reg <= '0;
            out_cnt_reg <= '0;
            err_reg <= ST_OK;
            start_cnt_reg <= '0;
        end else begin
            if (cfg_wr_en) cap_reg <= cfg_wr_data;
            phase_reg <= phase_next;
            hstep_reg <= hstep_next;
            seg_left_reg <= seg_left_next;
            len_hi_reg <= len_hi_next;
            marker_reg <= marker_next;
            restart_reg <= restart_next;
            held0_reg <= held0_next;
            held1_reg <= held1_next;
            held_cnt_reg <= held_cnt_next;
            out_cnt_reg <= out_cnt_next;
            err_reg <= err_next;
            start_cnt_reg <= start_cnt_next;
        end
    end

endmodule

FILE: hw/rtl/bss_queue.sv
// Command queue between the front end and the result sequencer.
// Depends on bss_pkg for the command type.
module bss_queue #(
    parameter int DEPTH = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    input  bss_pkg::cmd_t in_cmd,
    output logic          in_ready,
    output logic          out_valid,
    output bss_pkg::cmd_t out_cmd,
    input  logic          out_pop
);
    import bss_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push, pop;

    assign in_ready = (count_reg != CNT_FULL);
    assign out_valid = (count_reg != '0);
    assign out_cmd = mem_reg[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop = out_pop && out_valid;

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= in_cmd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            if (push) wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (pop) rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop) count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL) else $error("queue count beyond depth");
    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not advance on push");

endmodule

FILE: hw/rtl/bss_back.sv
// Result sequencer: expands each queued command into result transfers.
// Depends on bss_pkg; drains bss_queue into the output register.
module bss_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    input  bss_pkg::cmd_t q_cmd,
    output logic          q_pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_out_byte,
    output logic          m_has_byte,
    output logic          m_out_last,
    output logic [2:0]    m_out_status
);
    import bss_pkg::*;

    logic [1:0] idx_reg;
    logic       m_valid_reg;
    logic [7:0] m_byte_reg;
    logic       m_has_reg;
    logic       m_last_reg;
    logic [2:0] m_status_reg;
    logic       load;
    logic       final_res;
    res_t       res_sel;

    assign load = q_valid && (!m_valid_reg || m_ready);
    assign res_sel = q_cmd.res[idx_reg];
    assign final_res = ({1'b0, idx_reg} == (q_cmd.count - 3'd1));
    assign q_pop = load && final_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg <= '0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                idx_reg <= final_res ? 2'd0 : idx_reg + 2'd1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_byte_reg <= res_sel.data;
            m_has_reg <= res_sel.has;
            m_last_reg <= res_sel.last;
            m_status_reg <= res_sel.status;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_out_byte = m_byte_reg;
    assign m_has_byte = m_has_reg;
    assign m_out_last = m_last_reg;
    assign m_out_status = m_status_reg;

    a_idx_holds_head: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg != 2'd0 |-> q_valid) else $error("command left mid-expansion");
    a_status_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_status_reg != ST_OK) |-> m_last_reg && !m_has_reg)
        else $error("error status on a non-final or data transfer");

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for jpeg_scan_byte_stuffer: directed and random JPEG-like frames in,
// stuffed stream out, checked against an in-bench prediction of every result.
// Depends on bss_pkg and the jpeg_scan_byte_stuffer RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bss_pkg::*;

    localparam int IDLE_PCT = 34;
    localparam int HOLD_CYCLES = 60;
    localparam int HOLD_AFTER = 30;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 6;
    localparam int TAIL_CYCLES = 20;
    localparam int REPORT_MAX = 10;
    localparam int N_PHASES = 6;
    localparam logic [3:0] HDR_GO = 4'd0;
    localparam logic [3:0] HDR_SOS_DONE = 4'd8;
    localparam logic [7:0] MARK_LO = 8'hc0;
    localparam logic [7:0] MARK_HI = 8'hfe;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } beat_t;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       last;
        logic [2:0] status;
    } outcome_t;

    logic              aclk;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [CAP_W-1:0]  cfg_wr_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [7:0]        s_in_byte = '0;
    logic              s_in_last = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [7:0]        m_out_byte;
    logic              m_has_byte;
    logic              m_out_last;
    logic [2:0]        m_out_status;

    beat_t    frame_feed[$];
    outcome_t stream_q[$];
    logic [7:0] frame_buf[$];

    logic in_took = 1'b0;
    logic calm = 1'b0;
    int   n_in = 0;
    int   misses = 0;
    int   quiet = 0;
    int   hold_left = 0;
    logic held_once = 1'b0;

    // predictor state
    int         cap_now;
    phase_t     ph;
    hstep_t     hs;
    logic [15:0] seg_left;
    logic [7:0] len_hi;
    logic [7:0] cur_mark;
    logic       rst_seen;
    logic [7:0] held [2];
    logic [1:0] held_n;
    int         out_n;
    logic [2:0] err;
    logic [2:0] starts;

    int         phase_budget [N_PHASES] = '{20, 30, 8, 25, 25, 25};
    logic [CAP_W-1:0] phase_cap [N_PHASES] = '{CAP_RESET, 21'd1048576, 21'd0, 21'd12,
                                                 21'd25, 21'd2097151};

    jpeg_scan_byte_stuffer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_in_last   (s_in_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_has_byte  (m_has_byte),
        .m_out_last  (m_out_last),
        .m_out_status(m_out_status)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic frame_reset();
        ph = PH_START;
        hs = HS_PREFIX;
        seg_left = '0;
        len_hi = '0;
        cur_mark = '0;
        rst_seen = 1'b0;
        held[0] = '0;
        held[1] = '0;
        held_n = '0;
        out_n = 0;
        err = ST_OK;
        starts = '0;
    endtask

    function automatic logic lone_marker(input logic [7:0] b);
        return b == BYTE_SOI || b == BYTE_TEM || (b >= BYTE_RST0 && b <= BYTE_RST7);
    endfunction

    function automatic logic [3:0] walk_header(input logic [7:0] b);
        logic [15:0] seg;
        logic [3:0] r;
        r = HDR_GO;
        seg = {len_hi, b};
        case (hs)
            HS_PREFIX: begin
                if (b != BYTE_FF) r = {1'b0, ST_BAD_HEADER};
                else hs = HS_MARK;
            end
            HS_MARK: begin
                if (b != BYTE_FF) begin
                    if (lone_marker(b)) begin
                        hs = HS_PREFIX;
                    end else if (b == BYTE_EOI) begin
                        r = {1'b0, ST_BAD_HEADER};
                    end else begin
                        cur_mark = b;
                        hs = HS_LEN_HI;
                    end
                end
            end
            HS_LEN_HI: begin
                len_hi = b;
                hs = HS_LEN_LO;
            end
            HS_LEN_LO: begin
                if (seg < 16'd2) begin
                    r = {1'b0, ST_BAD_HEADER};
                end else begin
                    if (cur_mark == BYTE_DRI) rst_seen = 1'b1;
                    if (seg == 16'd2) begin
                        hs = HS_PREFIX;
                        if (cur_mark == BYTE_SOS) r = HDR_SOS_DONE;
                    end else begin
                        seg_left = seg - 16'd2;
                        hs = HS_BODY;
                    end
                end
            end
            default: begin
                seg_left = seg_left - 16'd1;
                if (seg_left == 16'd0) begin
                    hs = HS_PREFIX;
                    if (cur_mark == BYTE_SOS) r = HDR_SOS_DONE;
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [2:0] header_tail_status(input logic [7:0] b);
        logic [2:0] st;
        logic ended;
        st = ST_BAD_HEADER;
        ended = 1'b0;
        case (hs)
            HS_PREFIX: st = ST_NO_SCAN;
            HS_MARK: if (lone_marker(b)) st = ST_NO_SCAN;
            HS_LEN_HI: st = ST_BAD_HEADER;
            HS_LEN_LO: ended = ({len_hi, b} == 16'd2);
            default: ended = (seg_left == 16'd1);
        endcase
        if (ended) begin
            if (cur_mark != BYTE_SOS) st = ST_NO_SCAN;
            else if (rst_seen) st = ST_RESTART;
            else st = ST_NO_END;
        end
        return st;
    endfunction

    task automatic fail_frame(input logic [2:0] code);
        if (err == ST_OK) err = code;
        ph = PH_DRAIN;
    endtask

    task automatic emit_byte(input logic [7:0] b, input logic lst);
        stream_q.push_back({b, 1'b1, lst, ST_OK});
    endtask

    task automatic stuff_byte(input logic [7:0] b, input logic lst);
        logic [2:0] st;
        logic [3:0] r;
        logic [7:0] prev;
        int cnt;
        if (starts < 3'd4) starts = starts + 3'd1;
        if (lst) begin
            st = err;
            if (st == ST_OK && starts < 3'd4) st = ST_BAD_START;
            if (st == ST_OK && ph == PH_HEADER) st = header_tail_status(b);
            if (st == ST_OK && ph == PH_SCAN) begin
                cnt = out_n;
                prev = (held_n == 2'd2) ? held[1] : held[0];
                if (held_n == 2'd0 || prev != BYTE_FF || b != BYTE_EOI) begin
                    st = ST_NO_END;
                end else begin
                    if (held_n == 2'd2) begin
                        if (cnt + 2 > cap_now) st = ST_CAPACITY;
                        else cnt += (held[0] == BYTE_FF) ? 2 : 1;
                    end
                    if (st == ST_OK && cap_now - cnt < 2) st = ST_CAPACITY;
                    if (st == ST_OK) begin
                        if (held_n == 2'd2) begin
                            emit_byte(held[0], 1'b0);
                            if (held[0] == BYTE_FF) emit_byte(BYTE_ZERO, 1'b0);
                        end
                        emit_byte(BYTE_FF, 1'b0);
                        emit_byte(BYTE_EOI, 1'b1);
                    end
                end
            end
            if (st != ST_OK || ph == PH_START || ph == PH_DRAIN) begin
                if (st == ST_OK) st = ST_BAD_START;
                stream_q.push_back({BYTE_ZERO, 1'b0, 1'b1, st});
            end
            frame_reset();
        end else begin
            case (ph)
                PH_START: begin
                    if ((starts == 3'd1 && b != BYTE_FF)
                            || (starts == 3'd2 && b != BYTE_SOI)) begin
                        fail_frame(ST_BAD_START);
                    end else if (out_n + 1 > cap_now) begin
                        fail_frame(ST_CAPACITY);
                    end else begin
                        out_n++;
                        emit_byte(b, 1'b0);
                        if (starts >= 3'd2) ph = PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    r = walk_header(b);
                    if (r != HDR_GO && r != HDR_SOS_DONE) begin
                        fail_frame(r[2:0]);
                    end else if (r == HDR_SOS_DONE && rst_seen) begin
                        fail_frame(ST_RESTART);
                    end else if (out_n + 1 > cap_now) begin
                        fail_frame(ST_CAPACITY);
                    end else begin
                        out_n++;
                        emit_byte(b, 1'b0);
                        if (r == HDR_SOS_DONE) begin
                            ph = PH_SCAN;
                            held_n = 2'd0;
                        end
                    end
                end
                PH_SCAN: begin
                    if (held_n < 2'd2) begin
                        held[held_n] = b;
                        held_n = held_n + 2'd1;
                    end else if (out_n + 2 > cap_now) begin
                        fail_frame(ST_CAPACITY);
                    end else begin
                        emit_byte(held[0], 1'b0);
                        out_n++;
                        if (held[0] == BYTE_FF) begin
                            emit_byte(BYTE_ZERO, 1'b0);
                            out_n++;
                        end
                        held[0] = held[1];
                        held[1] = b;
                    end
                end
                default: ;
            endcase
        end
    endtask

    task automatic flag_result(input string why, input outcome_t want, input outcome_t got);
        misses++;
        if (misses <= REPORT_MAX)
            $display("%0t %s: want byte %02h has %0d last %0d status %0d,",
                     $time, why, want.data, want.has, want.last, want.status,
                     " got byte %02h has %0d last %0d status %0d",
                     got.data, got.has, got.last, got.status);
    endtask

    task automatic send_frame();
        beat_t bt;
        foreach (frame_buf[i]) begin
            bt.data = frame_buf[i];
            bt.last = (i == frame_buf.size() - 1);
            frame_feed.push_back(bt);
        end
    endtask

    task automatic add_segment(input logic [7:0] mk, input int body_len);
        logic [15:0] seg_len;
        seg_len = 16'(body_len + 2);
        frame_buf.push_back(BYTE_FF);
        if ($urandom_range(3) == 0) frame_buf.push_back(BYTE_FF);
        frame_buf.push_back(mk);
        frame_buf.push_back(seg_len[15:8]);
        frame_buf.push_back(seg_len[7:0]);
        repeat (body_len) frame_buf.push_back(8'($urandom_range(255)));
    endtask

    task automatic add_lone_marker();
        frame_buf.push_back(BYTE_FF);
        if ($urandom_range(3) == 0) frame_buf.push_back(BYTE_FF);
        case ($urandom_range(2))
            0: frame_buf.push_back(BYTE_SOI);
            1: frame_buf.push_back(BYTE_RST0 + 8'($urandom_range(7)));
            default: frame_buf.push_back(BYTE_TEM);
        endcase
    endtask

    task automatic make_frame(output int len);
        int pick;
        int cut;
        int r;
        logic [7:0] mk;
        frame_buf.delete();
        pick = $urandom_range(99);
        if (pick < 10) begin
            repeat ($urandom_range(1, 8)) frame_buf.push_back(8'($urandom_range(255)));
        end else begin
            frame_buf.push_back(BYTE_FF);
            frame_buf.push_back(BYTE_SOI);
            repeat ($urandom_range(0, 2)) begin
                if ($urandom_range(2) == 0) begin
                    add_lone_marker();
                end else begin
                    mk = 8'($urandom_range(MARK_LO, MARK_HI));
                    if (mk[7:4] == BYTE_RST0[7:4]) mk = {MARK_HI[7:4], mk[3:0]};
                    add_segment(mk, $urandom_range(0, 3));
                end
            end
            if ($urandom_range(9) == 0) add_segment(BYTE_DRI, 2);
            add_segment(BYTE_SOS, $urandom_range(0, 6));
            repeat ($urandom_range(0, 12)) begin
                r = $urandom_range(99);
                if (r < 30) frame_buf.push_back(BYTE_FF);
                else if (r < 38) frame_buf.push_back(BYTE_EOI);
                else if (r < 45) frame_buf.push_back(BYTE_ZERO);
                else frame_buf.push_back(8'($urandom_range(255)));
            end
            frame_buf.push_back(BYTE_FF);
            frame_buf.push_back(BYTE_EOI);
            if (pick >= 75) begin
                case ($urandom_range(3))
                    0: begin
                        cut = $urandom_range(1, frame_buf.size() - 1);
                        frame_buf = frame_buf[0:cut-1];
                    end
                    1: frame_buf[$urandom_range(frame_buf.size() - 1)] = 8'($urandom_range(255));
                    2: repeat ($urandom_range(1, 3)) frame_buf.push_back(8'($urandom_range(255)));
                    default: begin
                        frame_buf.insert(2, BYTE_FF);
                        frame_buf.insert(3, MARK_LO);
                        frame_buf.insert(4, BYTE_ZERO);
                        frame_buf.insert(5, 8'($urandom_range(1)));
                    end
                endcase
            end
        end
        len = frame_buf.size();
        send_frame();
    endtask

    task automatic wait_drained();
        while (frame_feed.size() != 0 || s_valid || stream_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] v);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cap_now = int'(v);
    endtask

    always @(negedge aclk) begin : drive_in
        beat_t nxt;
        if (aresetn && (!s_valid || in_took)) begin
            if (frame_feed.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                nxt = frame_feed.pop_front();
                s_valid <= 1'b1;
                s_in_byte <= nxt.data;
                s_in_last <= nxt.last;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin : drive_out
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!held_once && n_in >= HOLD_AFTER) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || $urandom_range(99) >= IDLE_PCT;
        end
    end

    always @(posedge aclk) begin : watch
        outcome_t got;
        outcome_t want;
        logic out_took;
        in_took = aresetn && s_valid && s_ready;
        out_took = aresetn && m_valid && m_ready;
        if (in_took) begin
            stuff_byte(s_in_byte, s_in_last);
            n_in++;
        end
        if (out_took) begin
            got = {m_out_byte, m_has_byte, m_out_last, m_out_status};
            if (stream_q.size() == 0) begin
                flag_result("unexpected result", '0, got);
            end else begin
                want = stream_q.pop_front();
                if (got.data !== want.data || got.has !== want.has ||
                    got.last !== want.last || got.status !== want.status)
                    flag_result("result mismatch", want, got);
            end
        end
        if (!aresetn || in_took || out_took) quiet = 0;
        else quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("%0t watchdog: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stim
        int added;
        int len;
        cap_now = int'(CAP_RESET);
        frame_reset();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        for (int p = 0; p < N_PHASES; p++) begin
            if (p > 0) begin
                wait_drained();
                set_capacity(phase_cap[p]);
            end
            calm = (p == 1);
            if (p == 0) begin
                frame_buf = {BYTE_FF};
                send_frame();
                frame_buf = {BYTE_ZERO, BYTE_SOI, BYTE_FF, BYTE_EOI};
                send_frame();
                frame_buf = {BYTE_FF, BYTE_SOI, BYTE_FF, BYTE_EOI};
                send_frame();
                frame_buf = {BYTE_FF, BYTE_SOI, BYTE_FF, BYTE_SOS, BYTE_ZERO, 8'd2,
                             BYTE_FF, BYTE_EOI};
                send_frame();
                frame_buf = {BYTE_FF, BYTE_SOI, BYTE_FF, MARK_LO, BYTE_ZERO, BYTE_TEM};
                send_frame();
            end
            added = 0;
            while (added < phase_budget[p]) begin
                make_frame(len);
                added += len;
            end
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (stream_q.size() != 0) begin
            $display("%0d expected results never arrived", stream_q.size());
            misses += stream_q.size();
        end
        if (misses == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: jpeg_scan_byte_stuffer.f
hw/rtl/bss_pkg.sv
hw/rtl/bss_front.sv
hw/rtl/bss_queue.sv
hw/rtl/bss_back.sv
hw/rtl/jpeg_scan_byte_stuffer.sv
dv/tb_top.sv
